// File: rtl/core/ordlst_pkg.sv
// Shared types and constants for the indexed ordered list.
// Used by the controller, the datapath and the top level; depends on nothing.
package ordlst_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int FUNC_W   = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

   localparam logic [FUNC_W-1:0] FUNC_INSERT_AT   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT_HEAD = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INSERT_TAIL = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE_AT   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE_HEAD = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_READ        = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      STATE_IDLE     = 5'b00001,
      STATE_DISPATCH = 5'b00010,
      STATE_SHIFT_WR = 5'b00100,
      STATE_PUT      = 5'b01000,
      STATE_DONE     = 5'b10000
   } state_type;

   typedef struct packed {
      logic load_req;
      logic mem_rd;
      logic shift_wr;
      logic value_wr;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic   ok;
      op_type kind;
      logic   more;
      logic   rsp_free;
   } sts_type;

endpackage

// File: rtl/core/ordlst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module ordlst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ordlst_ctrl.sv
// Sequencer for the indexed ordered list: accepts a request, walks the shift loop.
// Depends on ordlst_pkg; drives commands into ordlst_dpath.
module ordlst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ordlst_pkg::sts_type  sts,
   output ordlst_pkg::cmd_type  cmd
);
   import ordlst_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = STATE_DISPATCH;
            end
         end
         STATE_DISPATCH: begin
            if (!sts.ok) begin
               state_in = STATE_DONE;
            end else begin
               case (sts.kind)
                  OP_INSERT: begin
                     if (sts.more) begin
                        cmd.mem_rd = 1'b1;
                        state_in   = STATE_SHIFT_WR;
                     end else begin
                        state_in = STATE_PUT;
                     end
                  end
                  OP_REMOVE: begin
                     if (sts.more) begin
                        cmd.mem_rd = 1'b1;
                        state_in   = STATE_SHIFT_WR;
                     end else begin
                        state_in = STATE_DONE;
                     end
                  end
                  OP_READ: begin
                     cmd.mem_rd = 1'b1;
                     state_in   = STATE_DONE;
                  end
                  default: begin
                     state_in = STATE_DONE;
                  end
               endcase
            end
         end
         STATE_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = STATE_DISPATCH;
         end
         STATE_PUT: begin
            cmd.value_wr = 1'b1;
            state_in     = STATE_DONE;
         end
         STATE_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != STATE_IDLE);

endmodule

// File: rtl/core/ordlst_dpath.sv
// Datapath for the indexed ordered list: request decode, count, shift pointer,
// element RAM and result register. Depends on ordlst_pkg and ordlst_ram.
module ordlst_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ordlst_pkg::cmd_type                    cmd,
   output ordlst_pkg::sts_type                    sts,
   input  logic [ordlst_pkg::FUNC_W-1:0]          req_func,
   input  logic [ordlst_pkg::POS_W-1:0]           req_position,
   input  logic signed [ordlst_pkg::VALUE_W-1:0]  req_item_value,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic [ordlst_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [ordlst_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [ordlst_pkg::COUNT_W-1:0]         rsp_count
);
   import ordlst_pkg::*;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [CNT_W-1:0]    ptr_ff;
   logic [CNT_W-1:0]    ptr_in;
   logic [CNT_W-1:0]    idx_ff;
   op_type              kind_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [VALUE_W-1:0]  value_ff;

   op_type              dec_kind;
   logic [CNT_W-1:0]    dec_idx;
   logic [STATUS_W-1:0] dec_status;
   logic                list_full;
   logic                list_empty;
   logic                pos_gt;
   logic                pos_ge;
   logic                shift_more;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [VALUE_W-1:0]     rsp_read_value_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;

   logic               op_ok;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   assign list_full  = (count_ff == CNT_W'(CAPACITY));
   assign list_empty = (count_ff == '0);
   assign pos_gt     = (CMP_W'(req_position) > CMP_W'(count_ff));
   assign pos_ge     = (CMP_W'(req_position) >= CMP_W'(count_ff));

   always_comb begin
      dec_kind   = OP_NONE;
      dec_idx    = CNT_W'(req_position);
      dec_status = STATUS_INDEX;
      case (req_func)
         FUNC_INSERT_AT: begin
            dec_kind   = OP_INSERT;
            dec_status = pos_gt ? STATUS_INDEX : (list_full ? STATUS_FULL : STATUS_OK);
         end
         FUNC_INSERT_HEAD: begin
            dec_kind   = OP_INSERT;
            dec_idx    = '0;
            dec_status = list_full ? STATUS_FULL : STATUS_OK;
         end
         FUNC_INSERT_TAIL: begin
            dec_kind   = OP_INSERT;
            dec_idx    = count_ff;
            dec_status = list_full ? STATUS_FULL : STATUS_OK;
         end
         FUNC_REMOVE_AT: begin
            dec_kind   = OP_REMOVE;
            dec_status = pos_ge ? STATUS_INDEX : STATUS_OK;
         end
         FUNC_REMOVE_HEAD: begin
            dec_kind   = OP_REMOVE;
            dec_idx    = '0;
            dec_status = list_empty ? STATUS_INDEX : STATUS_OK;
         end
         FUNC_READ: begin
            dec_kind   = OP_READ;
            dec_status = pos_ge ? STATUS_INDEX : STATUS_OK;
         end
         default: begin
            dec_kind   = OP_NONE;
            dec_status = STATUS_INDEX;
         end
      endcase
   end

   assign op_ok = (status_ff == STATUS_OK);

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load_req) begin
         ptr_in = (dec_kind == OP_INSERT) ? count_ff : dec_idx;
      end else if (cmd.shift_wr) begin
         ptr_in = (kind_ff == OP_INSERT) ? (ptr_ff - CNT_W'(1)) : (ptr_ff + CNT_W'(1));
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load_rsp && op_ok) begin
         case (kind_ff)
            OP_INSERT: count_in = count_ff + CNT_W'(1);
            OP_REMOVE: count_in = count_ff - CNT_W'(1);
            default:   count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load_req) begin
         kind_ff   <= dec_kind;
         idx_ff    <= dec_idx;
         status_ff <= dec_status;
         value_ff  <= req_item_value;
      end
   end

   always_comb begin
      case (kind_ff)
         OP_INSERT: shift_more = (ptr_ff > idx_ff);
         OP_REMOVE: shift_more = ((ptr_ff + CNT_W'(1)) < count_ff);
         default:   shift_more = 1'b0;
      endcase
   end

   always_comb begin
      case (kind_ff)
         OP_INSERT: ram_rd_addr = IDX_W'(ptr_ff - CNT_W'(1));
         OP_REMOVE: ram_rd_addr = IDX_W'(ptr_ff + CNT_W'(1));
         default:   ram_rd_addr = IDX_W'(idx_ff);
      endcase
   end

   assign ram_wr_en   = cmd.shift_wr | cmd.value_wr;
   assign ram_wr_addr = cmd.shift_wr ? IDX_W'(ptr_ff) : IDX_W'(idx_ff);
   assign ram_wr_data = cmd.shift_wr ? ram_rd_data : value_ff;

   ordlst_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.mem_rd),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff     <= status_ff;
         rsp_read_value_ff <= ((kind_ff == OP_READ) && op_ok) ? ram_rd_data : '0;
         rsp_count_ff      <= COUNT_W'(count_in);
      end
   end

   assign sts.ok       = op_ok;
   assign sts.kind     = kind_ff;
   assign sts.more     = shift_more;
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = $signed(rsp_read_value_ff);
   assign rsp_count      = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count beyond capacity");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over an unaccepted beat");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.load_rsp |=> $stable(count_ff))
      else $error("count changed outside result load");

   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> op_ok)
      else $error("element write on a failed request");
`endif

endmodule

// File: rtl/core/indexed_ordered_list.sv
// Top level of the indexed ordered list: sequencer plus datapath.
// Depends on ordlst_pkg, ordlst_ctrl, ordlst_dpath and ordlst_ram.
//
//   channel | valid     | stall     | payload
//   req     | req_valid | req_stall | req_func, req_position, req_item_value
//   rsp     | rsp_valid | rsp_stall | rsp_status, rsp_read_value, rsp_count
//
// One request at a time. A read or failed request goes through dispatch, then done.
// An insert or remove passes dispatch and shift-write once per moved entry (insert adds a put),
// each moved entry costing a RAM read then a RAM write through the one element RAM.
// Reset clears the count, the control state and the result valid flag; the element RAM is not cleared.
// A result waits in the output register; the next request is taken meanwhile and
// its result is held back until that beat leaves.
module indexed_ordered_list (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ordlst_pkg::FUNC_W-1:0]          req_func,
   input  logic [ordlst_pkg::POS_W-1:0]           req_position,
   input  logic signed [ordlst_pkg::VALUE_W-1:0]  req_item_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ordlst_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [ordlst_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [ordlst_pkg::COUNT_W-1:0]         rsp_count
);
   import ordlst_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ordlst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ordlst_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

endmodule

// File: tb/indexed_ordered_list_tb.sv
// Self-checking testbench for the indexed ordered list: random requests, idling on both sides.
// A scoreboard class keeps its own copy of the list and checks every result beat.
// Depends on ordlst_pkg and the indexed_ordered_list top level.
module indexed_ordered_list_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ordlst_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int          PHASE_ITEMS   = 150;
   localparam int          PHASE_COUNT   = 12;
   localparam int          DRAIN_CYCLES  = 140;

   typedef enum {LOAD_GROW, LOAD_MIX, LOAD_SHRINK} load_kind_type;

   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0]        count;
   } list_result_type;

   class list_scoreboard;
      list_result_type           awaited[$];
      logic signed [VALUE_W-1:0] slots[CAPACITY];
      int unsigned               fill;
      int unsigned               errors;

      function logic [STATUS_W-1:0] insert_at(int unsigned idx, logic signed [VALUE_W-1:0] value);
         if (idx > fill) return STATUS_INDEX;
         if (fill >= CAPACITY) return STATUS_FULL;
         for (int unsigned i = fill; i > idx; i--) slots[i] = slots[i - 1];
         slots[idx] = value;
         fill++;
         return STATUS_OK;
      endfunction

      function logic [STATUS_W-1:0] remove_at(int unsigned idx);
         if (idx >= fill) return STATUS_INDEX;
         for (int unsigned i = idx; i + 1 < fill; i++) slots[i] = slots[i + 1];
         fill--;
         return STATUS_OK;
      endfunction

      function void note_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                 logic signed [VALUE_W-1:0] value);
         list_result_type r;
         r.status     = STATUS_INDEX;
         r.read_value = '0;
         case (func)
            FUNC_INSERT_AT:   r.status = insert_at(pos, value);
            FUNC_INSERT_HEAD: r.status = insert_at(0, value);
            FUNC_INSERT_TAIL: r.status = insert_at(fill, value);
            FUNC_REMOVE_AT:   r.status = remove_at(pos);
            FUNC_REMOVE_HEAD: r.status = remove_at(0);
            FUNC_READ: begin
               if (pos < fill) begin
                  r.read_value = slots[pos];
                  r.status     = STATUS_OK;
               end
            end
            default: r.status = STATUS_INDEX;
         endcase
         r.count = COUNT_W'(fill);
         awaited.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status,
                                   logic signed [VALUE_W-1:0] read_value,
                                   logic [COUNT_W-1:0] count);
         list_result_type want;
         if (awaited.size() == 0) begin
            $error("result beat with no request outstanding");
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, read_value);
            errors++;
         end
         if (count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, count);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [FUNC_W-1:0]         req_func = FUNC_READ;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic [COUNT_W-1:0]        rsp_count;

   list_scoreboard sb;
   bit             steady = 1'b0;
   int unsigned    stall_left = 0;
   int unsigned    cycles = 0;

   indexed_ordered_list uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned draw_wait();
      return steady ? 0 : $urandom_range(0, 6);
   endfunction

   task automatic send_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                               logic signed [VALUE_W-1:0] value);
      int unsigned gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_position   <= pos;
      req_item_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(func, pos, value);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      int unsigned hold;
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_status, rsp_read_value, rsp_count);
         hold = draw_wait();
         rsp_stall  <= (hold != 0);
         stall_left <= hold;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      load_kind_type             kind;
      int unsigned               r;
      logic [FUNC_W-1:0]         func;
      logic [POS_W-1:0]          pos;
      logic signed [VALUE_W-1:0] value;

      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list, bad indexes, extremes of value and position
      send_request(FUNC_READ, 7'd0, 32'sd0);
      send_request(FUNC_REMOVE_HEAD, 7'd0, 32'sd0);
      send_request(FUNC_REMOVE_AT, 7'd0, 32'sd0);
      send_request(FUNC_INSERT_AT, 7'd1, 32'sd5);
      send_request(FUNC_INSERT_AT, 7'd0, 32'sh7fff_ffff);
      send_request(FUNC_INSERT_HEAD, 7'd127, 32'sh8000_0000);
      send_request(FUNC_INSERT_TAIL, 7'd127, -32'sd1);
      send_request(FUNC_INSERT_AT, 7'd3, 32'sd0);
      send_request(FUNC_INSERT_AT, 7'd1, 32'sh5a5a_a5a5);
      for (int i = 0; i <= 5; i++) send_request(FUNC_READ, POS_W'(i), -32'sd1);
      send_request(FUNC_READ, 7'd127, 32'sd0);
      send_request(FUNC_SPARE_6, 7'd127, -32'sd1);
      send_request(FUNC_SPARE_7, 7'd0, 32'sd0);
      send_request(FUNC_REMOVE_AT, 7'd127, 32'sd0);
      send_request(FUNC_INSERT_AT, 7'd64, 32'sd1);
      send_request(FUNC_INSERT_AT, 7'd127, 32'sd2);
      send_request(FUNC_REMOVE_AT, 7'd2, 32'sd0);
      send_request(FUNC_REMOVE_HEAD, 7'd0, 32'sd0);
      send_request(FUNC_READ, 7'd1, 32'sd0);
      drain_results();

      // grow to full, churn, then shrink to empty, over and over
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         kind   = load_kind_type'(phase % 3);
         steady = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            case (kind)
               LOAD_GROW:
                  func = (r < 28) ? FUNC_INSERT_AT : (r < 56) ? FUNC_INSERT_HEAD :
                         (r < 85) ? FUNC_INSERT_TAIL : (r < 90) ? FUNC_REMOVE_AT :
                         (r < 94) ? FUNC_REMOVE_HEAD : (r < 99) ? FUNC_READ : FUNC_SPARE_6;
               LOAD_MIX:
                  func = (r < 12) ? FUNC_INSERT_AT : (r < 21) ? FUNC_INSERT_HEAD :
                         (r < 30) ? FUNC_INSERT_TAIL : (r < 45) ? FUNC_REMOVE_AT :
                         (r < 56) ? FUNC_REMOVE_HEAD : (r < 98) ? FUNC_READ : FUNC_SPARE_7;
               default:
                  func = (r < 5) ? FUNC_INSERT_AT : (r < 10) ? FUNC_INSERT_HEAD :
                         (r < 15) ? FUNC_INSERT_TAIL : (r < 50) ? FUNC_REMOVE_AT :
                         (r < 80) ? FUNC_REMOVE_HEAD : (r < 98) ? FUNC_READ : FUNC_SPARE_6;
            endcase
            if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, 127));
            else pos = POS_W'($urandom_range(0, sb.fill));
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 3))
                  0: value = 32'sd0;
                  1: value = -32'sd1;
                  2: value = 32'sh8000_0000;
                  default: value = 32'sh7fff_ffff;
               endcase
            end else begin
               value = $urandom;
            end
            send_request(func, pos, value);
         end
         drain_results();
      end

      steady = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
